FILE: sv/fsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared types for the multi-server FIFO dispatcher.
// ----------------------------------------------------------------------------
package fsd_pkg;

  // Sequencer states of the dispatcher.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SERVE,
    ST_LOAD,
    ST_FINISH
  } fsd_state_t;

endpackage

FILE: sv/fsd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/fifo_multi_server_dispatcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_multi_server_dispatcher_top
// A FIFO of job service times feeding a set of servers with countdowns.
// ----------------------------------------------------------------------------
// Usage: each input word carries kind, arrive and service_time. A kind 0
// word only enqueues an arriving job; a kind 1 word is one time tick, which
// first enqueues an arriving job and then visits the servers in index order.
// A free server takes the job at the FIFO head, a busy server counts down,
// and one reaching zero is freed and counted as a completion. Every input
// word produces exactly one status word on the out_ channel.
// Sequence: a kind 0 word goes from acceptance to ST_FINISH, where its result
// is registered; a tick visits the servers in ST_SERVE, with an ST_LOAD step
// added for each server that takes a new job, since the job store has a
// registered read port. The next word is accepted in the cycle after the
// result is registered. The servers share one decrementer and are visited
// one at a time in index order. in_stall is high while a word is being
// worked on, so one word is in flight at a time.
// Reset (synchronous, rst_n low) empties the FIFO, frees every server and
// clears both totals; no clearing pass is needed. When out_stall holds the
// output, the block may accept and work on the next word, and waits with
// its result until the pending output word is taken.
// ----------------------------------------------------------------------------
module fifo_multi_server_dispatcher_top
  import fsd_pkg::*;
#(
  parameter int NUM_SERVERS = 3,
  parameter int QUEUE_DEPTH = 64,
  parameter int TIME_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic        in_arrive,
  input  logic [7:0]  in_service_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_queue_count,
  output logic [2:0]  out_busy_mask,
  output logic [1:0]  out_done_now,
  output logic [31:0] out_completed_total,
  output logic [31:0] out_arrivals_total,
  output logic        out_dropped
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SIDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int DONE_W = $clog2(NUM_SERVERS + 1);

  // Control and state registers.
  fsd_state_t             state_r, state_nxt;
  logic                   drop_r, drop_nxt;
  logic [SIDX_W-1:0]      srv_r, srv_nxt;
  logic [PTR_W-1:0]       head_r, head_nxt;
  logic [PTR_W-1:0]       tail_r, tail_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [NUM_SERVERS-1:0] busy_r, busy_nxt;
  logic [TIME_BITS-1:0]   rem_r [NUM_SERVERS];
  logic [TIME_BITS-1:0]   rem_nxt [NUM_SERVERS];
  logic [DONE_W-1:0]      done_r, done_nxt;
  logic [31:0]            total_r, total_nxt;
  logic [31:0]            arrivals_r, arrivals_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Output payload registers.
  logic [6:0]  out_count_r, out_count_nxt;
  logic [2:0]  out_mask_r, out_mask_nxt;
  logic [1:0]  out_done_r, out_done_nxt;
  logic [31:0] out_total_r, out_total_nxt;
  logic [31:0] out_arr_r, out_arr_nxt;
  logic        out_drop_r, out_drop_nxt;

  // Job store interface.
  logic                 ram_we;
  logic                 ram_re;
  logic [TIME_BITS-1:0] ram_wdata;
  logic [TIME_BITS-1:0] ram_rdata;

  // Shared decrementer and helper signals.
  logic [TIME_BITS-1:0]           dec_in;
  logic [TIME_BITS-1:0]           dec_out;
  logic                           in_accept;
  logic                           full;
  logic                           last_srv;
  logic                           out_free;
  logic                           take_job;
  logic [TIME_BITS+7:0]           stime_ext;
  logic [CNT_W+6:0]               count_ext;
  logic [NUM_SERVERS+2:0]         mask_ext;
  logic [DONE_W+1:0]              done_ext;

  fsd_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // Pointer advance with wrap at the queue depth.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // Handshake and simple status terms.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign last_srv  = (srv_r == SIDX_W'(NUM_SERVERS - 1));
  assign out_free  = !out_valid_r || !out_stall;
  assign take_job  = !busy_r[srv_r] && (count_r != '0);
  assign stime_ext = {{TIME_BITS{1'b0}}, in_service_time};
  assign ram_wdata = stime_ext[TIME_BITS-1:0];
  assign ram_we    = in_accept && in_arrive && !full;
  assign ram_re    = (state_r == ST_SERVE) && take_job;

  // The one countdown unit: a freshly read job or a running count.
  assign dec_in  = (state_r == ST_LOAD) ? ram_rdata : rem_r[srv_r];
  assign dec_out = dec_in - TIME_BITS'(1);

  // Output fields are the state masked to the port widths.
  assign count_ext = {7'b0, count_r};
  assign mask_ext  = {3'b0, busy_nxt};
  assign done_ext  = {2'b0, done_r};

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = in_kind ? ST_SERVE : ST_FINISH;
        end
      end
      ST_SERVE: begin
        if (take_job) begin
          state_nxt = ST_LOAD;
        end else if (last_srv) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_LOAD: begin
        state_nxt = last_srv ? ST_FINISH : ST_SERVE;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    drop_nxt      = drop_r;
    srv_nxt       = srv_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    busy_nxt      = busy_r;
    rem_nxt       = rem_r;
    done_nxt      = done_r;
    total_nxt     = total_r;
    arrivals_nxt  = arrivals_r;
    out_count_nxt = out_count_r;
    out_mask_nxt  = out_mask_r;
    out_done_nxt  = out_done_r;
    out_total_nxt = out_total_r;
    out_arr_nxt   = out_arr_r;
    out_drop_nxt  = out_drop_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        // Take the word and enqueue an arriving job if there is room.
        if (in_accept) begin
          drop_nxt = in_arrive && full;
          srv_nxt  = '0;
          done_nxt = '0;
          if (ram_we) begin
            tail_nxt     = ptr_inc(tail_r);
            count_nxt    = count_r + CNT_W'(1);
            arrivals_nxt = arrivals_r + 32'd1;
          end
        end
      end
      ST_SERVE: begin
        // A busy server counts down; a free one with a job waiting waits for its job read.
        if (!take_job) begin
          if (busy_r[srv_r]) begin
            rem_nxt[srv_r] = dec_out;
            if (dec_out == '0) begin
              busy_nxt[srv_r] = 1'b0;
              done_nxt        = done_r + DONE_W'(1);
              total_nxt       = total_r + 32'd1;
            end
          end
          if (!last_srv) begin
            srv_nxt = srv_r + SIDX_W'(1);
          end
        end
      end
      ST_LOAD: begin
        // Dispatch the head job and count its first tick.
        head_nxt        = ptr_inc(head_r);
        count_nxt       = count_r - CNT_W'(1);
        rem_nxt[srv_r]  = dec_out;
        busy_nxt[srv_r] = (dec_out != '0);
        if (dec_out == '0) begin
          done_nxt  = done_r + DONE_W'(1);
          total_nxt = total_r + 32'd1;
        end
        if (!last_srv) begin
          srv_nxt = srv_r + SIDX_W'(1);
        end
      end
      ST_FINISH: begin
        // Publish the status word once the output register is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_ext[6:0];
          out_mask_nxt  = mask_ext[2:0];
          out_done_nxt  = done_ext[1:0];
          out_total_nxt = total_r;
          out_arr_nxt   = arrivals_r;
          out_drop_nxt  = drop_r;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      busy_r      <= '0;
      total_r     <= '0;
      arrivals_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SERVERS; i++) begin
        rem_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      total_r     <= total_nxt;
      arrivals_r  <= arrivals_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
    end
  end

  // Per-word working registers and output payload.
  always_ff @(posedge clk) begin
    drop_r      <= drop_nxt;
    srv_r       <= srv_nxt;
    done_r      <= done_nxt;
    out_count_r <= out_count_nxt;
    out_mask_r  <= out_mask_nxt;
    out_done_r  <= out_done_nxt;
    out_total_r <= out_total_nxt;
    out_arr_r   <= out_arr_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_queue_count     = out_count_r;
  assign out_busy_mask       = out_mask_r;
  assign out_done_now        = out_done_r;
  assign out_completed_total = out_total_r;
  assign out_arrivals_total  = out_arr_r;
  assign out_dropped         = out_drop_r;

endmodule

FILE: dv/fifo_multi_server_dispatcher_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_multi_server_dispatcher_top_test
// Self-checking testbench for the multi-server FIFO dispatcher.
// ----------------------------------------------------------------------------
// Every accepted input word is run through a behavioral model of the job
// FIFO and the three servers, and the predicted status word is queued. Each
// status word taken from the out_ channel is compared field by field with
// the oldest prediction. Directed tests cover idle steps, same-tick
// completion, a full FIFO and long countdowns. Random traffic follows, with
// bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module fifo_multi_server_dispatcher_top_test;

  localparam int NUM_SRV    = 3;
  localparam int FIFO_DEPTH = 64;

  // One predicted status word.
  typedef struct packed {
    logic [6:0]  queue_count;
    logic [2:0]  busy_mask;
    logic [1:0]  done_now;
    logic [31:0] completed_total;
    logic [31:0] arrivals_total;
    logic        dropped;
  } status_t;

  // Receiver stall patterns.
  typedef enum int {
    STALL_NONE,
    STALL_SPARSE,
    STALL_HEAVY
  } stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic        in_arrive = 1'b0;
  logic [7:0]  in_service_time = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_queue_count;
  logic [2:0]  out_busy_mask;
  logic [1:0]  out_done_now;
  logic [31:0] out_completed_total;
  logic [31:0] out_arrivals_total;
  logic        out_dropped;

  // Model state of the FIFO and the servers.
  logic [7:0]  fifo_times [FIFO_DEPTH];
  logic [5:0]  fifo_head = '0;
  logic [5:0]  fifo_tail = '0;
  logic [6:0]  fifo_count = '0;
  logic [2:0]  server_on = '0;
  logic [7:0]  server_left [NUM_SRV];
  logic [31:0] done_total = '0;
  logic [31:0] arrival_total = '0;

  status_t     expected_status [$];
  status_t     status_want;
  int          error_count = 0;

  // Sender burst control and receiver stall control.
  int          burst_left = 1;
  int          gap_max = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_tick = 0;

  fifo_multi_server_dispatcher_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_arrive           (in_arrive),
    .in_service_time     (in_service_time),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_queue_count     (out_queue_count),
    .out_busy_mask       (out_busy_mask),
    .out_done_now        (out_done_now),
    .out_completed_total (out_completed_total),
    .out_arrivals_total  (out_arrivals_total),
    .out_dropped         (out_dropped)
  );

  always #6 clk = ~clk;

  // Advance the model by one word and return the status it should report.
  function automatic status_t predict_status(logic kind, logic arrive, logic [7:0] stime);
    status_t s;
    int      i;
    s = '0;
    // An arriving job is enqueued first, or dropped when the FIFO is full.
    if (arrive) begin
      if (fifo_count >= FIFO_DEPTH) begin
        s.dropped = 1'b1;
      end else begin
        fifo_times[fifo_tail] = stime;
        fifo_tail = fifo_tail + 6'd1;
        fifo_count = fifo_count + 7'd1;
        arrival_total = arrival_total + 32'd1;
      end
    end
    if (kind) begin
      // Free servers take jobs from the head in index order.
      for (i = 0; i < NUM_SRV; i++) begin
        if (!server_on[i] && fifo_count != 0) begin
          server_on[i] = 1'b1;
          server_left[i] = fifo_times[fifo_head];
          fifo_head = fifo_head + 6'd1;
          fifo_count = fifo_count - 7'd1;
        end
      end
      // Busy servers count down; a wrap from zero gives a full-length job.
      for (i = 0; i < NUM_SRV; i++) begin
        if (server_on[i]) begin
          server_left[i] = server_left[i] - 8'd1;
          if (server_left[i] == 8'd0) begin
            server_on[i] = 1'b0;
            s.done_now = s.done_now + 2'd1;
            done_total = done_total + 32'd1;
          end
        end
      end
    end
    s.queue_count = fifo_count;
    s.busy_mask = server_on;
    s.completed_total = done_total;
    s.arrivals_total = arrival_total;
    return s;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Compare each result word with the oldest prediction, then predict the
  // word accepted on this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $error("result word with no prediction waiting");
          error_count++;
        end else begin
          status_want = expected_status.pop_front();
          check_field("queue_count", 32'(status_want.queue_count), 32'(out_queue_count));
          check_field("busy_mask", 32'(status_want.busy_mask), 32'(out_busy_mask));
          check_field("done_now", 32'(status_want.done_now), 32'(out_done_now));
          check_field("completed_total", status_want.completed_total, out_completed_total);
          check_field("arrivals_total", status_want.arrivals_total, out_arrivals_total);
          check_field("dropped", 32'(status_want.dropped), 32'(out_dropped));
        end
      end
      if (in_valid && !in_stall) begin
        expected_status.push_back(predict_status(in_kind, in_arrive, in_service_time));
      end
    end
  end

  // Receiver stall pattern, changed at the falling edge.
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_SPARSE: begin
        out_stall <= ($urandom_range(0, 99) < 30);
      end
      default: begin
        out_stall <= ((stall_tick % 23) < 9) || ($urandom_range(0, 99) < 15);
      end
    endcase
  end

  // Hold the input idle for a number of cycles with random payload.
  task automatic idle_input(int cycles);
    in_valid = 1'b0;
    in_kind = 1'($urandom_range(0, 1));
    in_arrive = 1'($urandom_range(0, 1));
    in_service_time = 8'($urandom_range(0, 255));
    repeat (cycles) @(negedge clk);
  endtask

  // Send one word; return at the falling edge after it is accepted, or after an input gap when a burst ends.
  task automatic send_word(logic kind, logic arrive, logic [7:0] stime);
    in_kind = kind;
    in_arrive = arrive;
    in_service_time = stime;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    // Bursts of random length separated by random gaps.
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max > 0) begin
        idle_input($urandom_range(0, gap_max));
      end
    end
  endtask

  task automatic wait_for_results();
    in_valid = 1'b0;
    while (expected_status.size() != 0) @(negedge clk);
  endtask

  // Tick with no arrivals until the FIFO is empty and every server is free.
  task automatic drain_servers();
    while (fifo_count != 0 || server_on != 3'b000) begin
      send_word(1'b1, 1'b0, 8'($urandom_range(0, 255)));
    end
  endtask

  // Steps with nothing arriving, including a tick with an empty FIFO.
  task automatic test_idle_status();
    stall_mode = STALL_NONE;
    gap_max = 0;
    send_word(1'b0, 1'b0, 8'hFF);
    send_word(1'b0, 1'b0, 8'h00);
    send_word(1'b1, 1'b0, 8'hA5);
  endtask

  // Short jobs: a one-tick job completes on the tick that dispatches it.
  task automatic test_short_jobs();
    stall_mode = STALL_SPARSE;
    gap_max = 3;
    send_word(1'b0, 1'b1, 8'd1);
    send_word(1'b1, 1'b0, 8'd0);
    send_word(1'b1, 1'b1, 8'd1);
    // All three servers finish together.
    send_word(1'b0, 1'b1, 8'd1);
    send_word(1'b0, 1'b1, 8'd1);
    send_word(1'b0, 1'b1, 8'd1);
    send_word(1'b1, 1'b0, 8'd0);
    // More jobs than servers, so one waits in the FIFO.
    send_word(1'b0, 1'b1, 8'd2);
    send_word(1'b0, 1'b1, 8'd3);
    send_word(1'b0, 1'b1, 8'd2);
    send_word(1'b0, 1'b1, 8'd5);
    repeat (6) send_word(1'b1, 1'b0, 8'd0);
  endtask

  // Fill the FIFO, then arrive while full on both kinds of word. The tick
  // drops its arrival even though dispatch frees room on the same tick.
  task automatic test_full_queue();
    stall_mode = STALL_HEAVY;
    gap_max = 4;
    drain_servers();
    while (fifo_count < FIFO_DEPTH) begin
      send_word(1'b0, 1'b1, 8'($urandom_range(1, 4)));
    end
    send_word(1'b0, 1'b1, 8'($urandom_range(1, 255)));
    send_word(1'b1, 1'b1, 8'd7);
    send_word(1'b1, 1'b1, 8'd3);
    drain_servers();
    wait_for_results();
  endtask

  // Longest countdowns: a zero service time runs for 256 ticks.
  task automatic test_long_jobs();
    stall_mode = STALL_NONE;
    gap_max = 0;
    send_word(1'b0, 1'b1, 8'd0);
    send_word(1'b0, 1'b1, 8'd255);
    send_word(1'b1, 1'b1, 8'd128);
    drain_servers();
  endtask

  // Random traffic in phases of different load, input gaps and stalls.
  task automatic test_random_traffic();
    int phase;
    int n;
    int tick_pct;
    int arrive_pct;
    int pick;
    logic [7:0] stime;
    for (phase = 0; phase < 10; phase++) begin
      tick_pct = $urandom_range(10, 90);
      arrive_pct = $urandom_range(20, 100);
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      gap_max = (phase == 3) ? 0 : $urandom_range(1, 10);
      if (phase == 3) stall_mode = STALL_NONE;
      // Pause until the block has answered everything so far.
      if (phase == 6) begin
        wait_for_results();
        idle_input($urandom_range(1, 8));
      end
      for (n = 0; n < 10; n++) begin
        pick = $urandom_range(0, 99);
        if (phase == 8 || pick < 5) stime = 8'($urandom_range(0, 255));
        else if (pick < 15) stime = 8'($urandom_range(9, 40));
        else stime = 8'($urandom_range(1, 8));
        send_word($urandom_range(0, 99) < tick_pct, $urandom_range(0, 99) < arrive_pct, stime);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_idle_status();
    test_short_jobs();
    test_full_queue();
    test_long_jobs();
    test_random_traffic();
    wait_for_results();
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("** fifo_multi_server_dispatcher_top: PASSED **");
    end else begin
      $display("** fifo_multi_server_dispatcher_top: FAILED **");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #(3_000_000);
    $display("** fifo_multi_server_dispatcher_top: FAILED **");
    $finish;
  end

endmodule

FILE: files.f
sv/fsd_pkg.sv
sv/fsd_ram.sv
sv/fifo_multi_server_dispatcher_top.sv
dv/fifo_multi_server_dispatcher_top_test.sv
